// ----- src/spq_pkg.sv -----
// Shared constants and types for the sorted priority queue.
`default_nettype none
package spq_pkg;

	// Default number of entries held
	localparam int DEPTH_DEF = 8;

	// Field widths
	localparam int VALUE_W  = 32;
	localparam int PRIO_W   = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 4;

	// Operation codes
	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic cap;   // capture the incoming item
		logic exec;  // apply the captured item and load the result register
	} cmd_t;

endpackage
`default_nettype wire

// ----- src/spq_req_if.sv -----
// Request channel: enqueue/dequeue items.
`default_nettype none
interface spq_req_if;
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic signed [spq_pkg::VALUE_W-1:0] value;
	logic        [spq_pkg::PRIO_W-1:0]  priority_req;

	modport source (output valid, kind, value, priority_req, input ready);
	modport sink   (input valid, kind, value, priority_req, output ready);
endinterface
`default_nettype wire

// ----- src/spq_rsp_if.sv -----
// Response channel: one result per request.
`default_nettype none
interface spq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic        [spq_pkg::STATUS_W-1:0] status;
	logic                                out_valid;
	logic signed [spq_pkg::VALUE_W-1:0]  out_value;
	logic        [spq_pkg::PRIO_W-1:0]   out_priority;
	logic        [spq_pkg::COUNT_W-1:0]  count;

	modport source (output valid, status, out_valid, out_value, out_priority, count,
		input ready);
	modport sink   (input valid, status, out_valid, out_value, out_priority, count,
		output ready);
endinterface
`default_nettype wire

// ----- src/sorted_priority_queue_top.sv -----
// Top level of the sorted priority queue.
// Bounded priority queue of DEPTH entries (value, priority) kept in ascending
// priority order with first-in first-out order among equal priorities. Each
// request (enqueue or dequeue) yields exactly one response carrying status,
// the removed entry on a successful dequeue, and the count held afterwards.
// An item is first captured and then executed: every cell compares and
// shifts in parallel and the result register is loaded, once an earlier
// result has been taken. The next request is taken once the previous one has
// executed, so a finished response may still wait in the output register.
`default_nettype none
module sorted_priority_queue_top #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);

	spq_pkg::cmd_t cmd;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	spq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.kind         (req.kind),
		.value        (req.value),
		.priority_req (req.priority_req),
		.status       (rsp.status),
		.out_valid    (rsp.out_valid),
		.out_value    (rsp.out_value),
		.out_priority (rsp.out_priority),
		.count        (rsp.count)
	);

endmodule
`default_nettype wire

// ----- src/spq_ctrl.sv -----
// Controller: capture / execute sequencing and result handshake.
`default_nettype none
module spq_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire logic         out_ready,
	output spq_pkg::cmd_t     cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic res_valid_q;
	logic slot_free;

	assign slot_free = !res_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = res_valid_q;

	// Commands to the datapath
	always_comb begin
		cmd.cap  = in_valid && in_ready;
		cmd.exec = (state_q == ST_EXEC) && slot_free;
	end

	// State sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.cap) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (cmd.exec) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// A result is never overwritten before its transfer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!res_valid_q || out_ready))
		else $error("result overwritten while pending");

	// A stalled result stays offered
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !out_ready) |=> res_valid_q)
		else $error("pending result dropped");

	// Every captured item is left pending execution
	a_cap_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap |=> (state_q == ST_EXEC))
		else $error("captured item not pending execution");

	// Capture and execution never happen in the same cycle
	a_exec_after_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !cmd.cap)
		else $error("capture and execute in same cycle");

endmodule
`default_nettype wire

// ----- src/spq_dp.sv -----
// Datapath: sorted cell row with parallel compare-and-shift, result register.
`default_nettype none
module spq_dp #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire spq_pkg::cmd_t                   cmd,
	input  wire logic                            kind,
	input  wire logic signed [spq_pkg::VALUE_W-1:0] value,
	input  wire logic        [spq_pkg::PRIO_W-1:0]  priority_req,
	output logic             [spq_pkg::STATUS_W-1:0] status,
	output logic                                 out_valid,
	output logic signed      [spq_pkg::VALUE_W-1:0]  out_value,
	output logic             [spq_pkg::PRIO_W-1:0]   out_priority,
	output logic             [spq_pkg::COUNT_W-1:0]  count
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	// Captured item
	logic                           kind_q;
	logic signed [spq_pkg::VALUE_W-1:0] value_q;
	logic        [spq_pkg::PRIO_W-1:0]  prio_q;

	// Cell row, slot 0 is the head
	logic signed [spq_pkg::VALUE_W-1:0] val_q [DEPTH];
	logic        [spq_pkg::PRIO_W-1:0]  pri_q [DEPTH];
	logic        [CNT_W-1:0]            cnt_q;

	// Result register
	logic        [spq_pkg::STATUS_W-1:0] status_q;
	logic                                 hit_q;
	logic signed [spq_pkg::VALUE_W-1:0]   rval_q;
	logic        [spq_pkg::PRIO_W-1:0]    rpri_q;
	logic        [CNT_W-1:0]              rcnt_q;

	logic             is_full;
	logic             is_empty;
	logic             do_enq;
	logic             do_deq;
	logic [DEPTH-1:0] gt;
	logic [CNT_W-1:0] cnt_nxt;

	assign is_full  = (cnt_q == CNT_W'(DEPTH));
	assign is_empty = (cnt_q == '0);
	assign do_enq   = cmd.exec && (kind_q == spq_pkg::KIND_ENQ) && !is_full;
	assign do_deq   = cmd.exec && (kind_q == spq_pkg::KIND_DEQ) && !is_empty;

	always_comb begin
		cnt_nxt = cnt_q;
		if (do_enq) cnt_nxt = cnt_q + 1'b1;
		else if (do_deq) cnt_nxt = cnt_q - 1'b1;
	end

	// Held cells ranked strictly behind the new priority
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (CNT_W'(i) < cnt_q) && (pri_q[i] > prio_q);
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			kind_q  <= kind;
			value_q <= value;
			prio_q  <= priority_req;
		end
	end

	// Per-cell update: shift back behind the insert point, shift forward on removal
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic                           from_prev;
		logic                           take_new;
		logic signed [spq_pkg::VALUE_W-1:0] prev_val;
		logic        [spq_pkg::PRIO_W-1:0]  prev_pri;
		logic signed [spq_pkg::VALUE_W-1:0] next_val;
		logic        [spq_pkg::PRIO_W-1:0]  next_pri;

		if (g == 0) begin : g_head
			assign from_prev = 1'b0;
			assign prev_val  = value_q;
			assign prev_pri  = prio_q;
		end else begin : g_body
			assign from_prev = gt[g-1];
			assign prev_val  = val_q[g-1];
			assign prev_pri  = pri_q[g-1];
		end

		if (g == DEPTH - 1) begin : g_tail
			assign next_val = val_q[g];
			assign next_pri = pri_q[g];
		end else begin : g_inner
			assign next_val = val_q[g+1];
			assign next_pri = pri_q[g+1];
		end

		assign take_new = gt[g] || (CNT_W'(g) == cnt_q);

		always_ff @(posedge clk) begin
			if (do_enq) begin
				if (from_prev) begin
					val_q[g] <= prev_val;
					pri_q[g] <= prev_pri;
				end else if (take_new) begin
					val_q[g] <= value_q;
					pri_q[g] <= prio_q;
				end
			end else if (do_deq) begin
				val_q[g] <= next_val;
				pri_q[g] <= next_pri;
			end
		end
	end

	// Held count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rcnt_q <= cnt_nxt;
			hit_q  <= do_deq;
			rval_q <= do_deq ? val_q[0] : '0;
			rpri_q <= do_deq ? pri_q[0] : '0;
			if (kind_q == spq_pkg::KIND_ENQ) begin
				status_q <= is_full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
			end else begin
				status_q <= is_empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
			end
		end
	end

	assign status       = status_q;
	assign out_valid    = hit_q;
	assign out_value    = rval_q;
	assign out_priority = rpri_q;
	assign count        = spq_pkg::COUNT_W'(rcnt_q);

endmodule
`default_nettype wire

// ----- tb/tb_sorted_priority_queue_top.sv -----
// Self-checking testbench for the sorted priority queue top level.
`timescale 1ns / 1ps
module tb_sorted_priority_queue_top;

	localparam int DEPTH = spq_pkg::DEPTH_DEF;
	localparam int STALL_LIMIT = 1000;
	localparam int TAIL_CYCLES = 20;
	localparam int RAND_PER_PHASE = 145;

	// One request waiting to be driven
	typedef struct {
		logic                               kind;
		logic signed [spq_pkg::VALUE_W-1:0] value;
		logic [spq_pkg::PRIO_W-1:0]         prio;
		int                                 phase;
		bit                                 drain;
	} req_item_t;

	// One predicted response
	typedef struct {
		logic [spq_pkg::STATUS_W-1:0]       status;
		logic                               out_valid;
		logic signed [spq_pkg::VALUE_W-1:0] out_value;
		logic [spq_pkg::PRIO_W-1:0]         out_priority;
		logic [spq_pkg::COUNT_W-1:0]        count;
	} rsp_item_t;

	logic clk = 1'b0;
	logic arst_n;

	spq_req_if req ();
	spq_rsp_if rsp ();

	sorted_priority_queue_top #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	req_item_t pending_req_q[$];
	rsp_item_t expected_rsp_q[$];
	int        mismatch_cnt = 0;
	int        cur_phase = 0;
	int        stall_cycles = 0;

	// Idle percentages per phase: sender, receiver
	int unsigned snd_idle_pct [3] = '{30, 69, 0};
	int unsigned rcv_idle_pct [3] = '{69, 30, 0};

	// Shadow copy of the sorted store
	logic signed [spq_pkg::VALUE_W-1:0] held_value [DEPTH];
	logic [spq_pkg::PRIO_W-1:0]         held_prio [DEPTH];
	int                                 held_n = 0;

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_error(string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	// Apply one request to the shadow store and return the response it yields
	function automatic rsp_item_t serve_request(logic kind,
		logic signed [spq_pkg::VALUE_W-1:0] value, logic [spq_pkg::PRIO_W-1:0] prio);
		rsp_item_t r;
		int        pos;
		bit        found;
		r.status       = spq_pkg::ST_OK;
		r.out_valid    = 1'b0;
		r.out_value    = '0;
		r.out_priority = '0;
		if (kind == spq_pkg::KIND_ENQ) begin
			if (held_n >= DEPTH) begin
				r.status = spq_pkg::ST_FULL;
			end else begin
				// insert behind every entry of equal or lower number
				pos = held_n;
				found = 1'b0;
				for (int i = 0; i < held_n; i++) begin
					if (!found && held_prio[i] > prio) begin
						pos = i;
						found = 1'b1;
					end
				end
				for (int i = held_n; i > pos; i--) begin
					held_value[i] = held_value[i-1];
					held_prio[i]  = held_prio[i-1];
				end
				held_value[pos] = value;
				held_prio[pos]  = prio;
				held_n++;
			end
		end else begin
			if (held_n == 0) begin
				r.status = spq_pkg::ST_EMPTY;
			end else begin
				r.out_valid    = 1'b1;
				r.out_value    = held_value[0];
				r.out_priority = held_prio[0];
				for (int i = 1; i < held_n; i++) begin
					held_value[i-1] = held_value[i];
					held_prio[i-1]  = held_prio[i];
				end
				held_n--;
			end
		end
		r.count = spq_pkg::COUNT_W'(held_n);
		return r;
	endfunction

	task automatic add_item(logic kind, logic signed [spq_pkg::VALUE_W-1:0] value,
		logic [spq_pkg::PRIO_W-1:0] prio, int phase, bit drain);
		req_item_t it;
		it.kind  = kind;
		it.value = value;
		it.prio  = prio;
		it.phase = phase;
		it.drain = drain;
		pending_req_q.push_back(it);
	endtask

	function automatic logic [spq_pkg::PRIO_W-1:0] rand_prio();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 60)
			return spq_pkg::PRIO_W'($urandom_range(7));
		else if (sel < 85)
			return spq_pkg::PRIO_W'($urandom_range(255));
		else if (sel < 93)
			return '0;
		else
			return '1;
	endfunction

	function automatic logic signed [spq_pkg::VALUE_W-1:0] rand_value();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 90)
			return $urandom;
		else if (sel < 95)
			return 32'sh7fffffff;
		else
			return 32'sh80000000;
	endfunction

	// Driver: presents pending requests, predicts each one on transfer
	always @(posedge clk or negedge arst_n) begin
		rsp_item_t exp_rsp;
		bit        go;
		if (!arst_n) begin
			req.valid        <= 1'b0;
			req.kind         <= spq_pkg::KIND_ENQ;
			req.value        <= '0;
			req.priority_req <= '0;
		end else if (!(req.valid && !req.ready)) begin
			if (req.valid && req.ready) begin
				exp_rsp = serve_request(req.kind, req.value, req.priority_req);
				expected_rsp_q.push_back(exp_rsp);
			end
			go = 1'b0;
			if (pending_req_q.size() != 0) begin
				go = ($urandom_range(99) >= snd_idle_pct[pending_req_q[0].phase]);
				if (pending_req_q[0].drain && expected_rsp_q.size() != 0)
					go = 1'b0;
			end
			if (go) begin
				req.valid        <= 1'b1;
				req.kind         <= pending_req_q[0].kind;
				req.value        <= pending_req_q[0].value;
				req.priority_req <= pending_req_q[0].prio;
				cur_phase        <= pending_req_q[0].phase;
				void'(pending_req_q.pop_front());
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Monitor: random backpressure, field-by-field compare on each transfer
	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= rcv_idle_pct[cur_phase]);
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp_q.size() == 0) begin
					report_error("response with no request outstanding");
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.status !== want.status)
						report_error($sformatf("status got %0d want %0d", rsp.status, want.status));
					if (rsp.out_valid !== want.out_valid)
						report_error($sformatf("out_valid got %0b want %0b",
							rsp.out_valid, want.out_valid));
					if (rsp.out_value !== want.out_value)
						report_error($sformatf("out_value got %h want %h",
							rsp.out_value, want.out_value));
					if (rsp.out_priority !== want.out_priority)
						report_error($sformatf("out_priority got %0d want %0d",
							rsp.out_priority, want.out_priority));
					if (rsp.count !== want.count)
						report_error($sformatf("count got %0d want %0d", rsp.count, want.count));
				end
			end
		end
	end

	// Watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", stall_cycles);
				$display("[sorted_priority_queue_top] ERROR");
				$finish;
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		bit fill_mode;
		int run_left;
		int enq_pct;
		arst_n = 1'b0;

		// directed: empty dequeue, field extremes, ties, full, drain to empty
		add_item(spq_pkg::KIND_DEQ, 32'sh7fffffff, 8'hff, 0, 1'b0);
		add_item(spq_pkg::KIND_ENQ, 32'sh7fffffff, 8'd255, 0, 1'b0);
		add_item(spq_pkg::KIND_ENQ, 32'sh80000000, 8'd0, 0, 1'b0);
		add_item(spq_pkg::KIND_ENQ, 32'sh00000000, 8'd128, 0, 1'b0);
		add_item(spq_pkg::KIND_ENQ, -32'sd1, 8'd128, 0, 1'b0);
		add_item(spq_pkg::KIND_ENQ, 32'sd1, 8'd128, 0, 1'b0);
		add_item(spq_pkg::KIND_ENQ, 32'sh55555555, 8'd0, 0, 1'b0);
		add_item(spq_pkg::KIND_ENQ, 32'shaaaaaaaa, 8'd255, 0, 1'b0);
		add_item(spq_pkg::KIND_ENQ, 32'sd12345, 8'd64, 0, 1'b0);
		add_item(spq_pkg::KIND_ENQ, 32'sh0badf00d, 8'd7, 0, 1'b0);
		add_item(spq_pkg::KIND_ENQ, -32'sd7, 8'd255, 0, 1'b0);
		for (int i = 0; i < DEPTH; i++)
			add_item(spq_pkg::KIND_DEQ, $urandom, spq_pkg::PRIO_W'($urandom_range(255)), 0,
				1'b0);
		add_item(spq_pkg::KIND_DEQ, 32'sh80000000, 8'h00, 0, 1'b0);
		add_item(spq_pkg::KIND_ENQ, 32'sh13579bdf, 8'h5a, 0, 1'b0);
		add_item(spq_pkg::KIND_DEQ, 32'sh0, 8'h0, 0, 1'b0);

		// random: fill and drain runs so the store swings between full and empty
		fill_mode = 1'b1;
		run_left  = 0;
		for (int ph = 0; ph < 3; ph++) begin
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				if (run_left == 0) begin
					fill_mode = ~fill_mode;
					run_left  = $urandom_range(14, 2);
				end
				run_left--;
				enq_pct = fill_mode ? 80 : 20;
				if ($urandom_range(99) < 5)
					enq_pct = 50;
				add_item(($urandom_range(99) < enq_pct) ? spq_pkg::KIND_ENQ : spq_pkg::KIND_DEQ,
					rand_value(), rand_prio(), ph, (i == 0) || ($urandom_range(99) < 2));
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_req_q.size() != 0 || req.valid || expected_rsp_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_rsp_q.size() != 0)
			report_error($sformatf("%0d responses never arrived", expected_rsp_q.size()));

		if (mismatch_cnt == 0) begin
			$display("[sorted_priority_queue_top] OK");
		end else begin
			$display("[sorted_priority_queue_top] ERROR");
		end
		$finish;
	end

endmodule
